FILE: hw/rtl/zbem_pkg.sv
// ----------------------------------------------------------------------------
// zbem_pkg
// Shared constants and types for the zero block extent mapper.
// ----------------------------------------------------------------------------
package zbem_pkg;

   localparam int unsigned DEF_OFFSET_BITS = 40;
   localparam int unsigned DEF_LANE_BYTES  = 8;
   localparam int unsigned DATA_BITS       = 64;
   localparam int unsigned VB_BITS         = 4;
   localparam int unsigned COUNT_BITS      = 16;

   localparam logic MODE_DATA = 1'b0;
   localparam logic MODE_EOF  = 1'b1;

   // one scanned item after the lanes are merged
   typedef struct packed {
      logic               mode;
      logic               nonzero;
      logic [VB_BITS-1:0] vb;
      logic               last;
   } scan_type;

endpackage

FILE: hw/rtl/zbem_req_if.sv
// ----------------------------------------------------------------------------
// zbem_req_if
// Input channel: file words and end-of-file markers.
// ----------------------------------------------------------------------------
interface zbem_req_if;
   logic                             valid;
   logic                             ready;
   logic                             mode;
   logic [zbem_pkg::DATA_BITS-1:0]   data_word;
   logic [zbem_pkg::VB_BITS-1:0]     valid_bytes;
   logic                             block_last;

   modport source (output valid, mode, data_word, valid_bytes, block_last, input ready);
   modport sink   (input valid, mode, data_word, valid_bytes, block_last, output ready);
endinterface

FILE: hw/rtl/zbem_rsp_if.sv
// ----------------------------------------------------------------------------
// zbem_rsp_if
// Result channel: data extents and running data total.
// ----------------------------------------------------------------------------
interface zbem_rsp_if #(
   parameter int unsigned OFFSET_BITS = zbem_pkg::DEF_OFFSET_BITS
);
   logic                   valid;
   logic                   ready;
   logic [OFFSET_BITS-1:0] extent_offset;
   logic [OFFSET_BITS-1:0] extent_length;
   logic [OFFSET_BITS-1:0] data_total;
   logic                   final_res;

   modport source (output valid, extent_offset, extent_length, data_total, final_res,
                   input ready);
   modport sink   (input valid, extent_offset, extent_length, data_total, final_res,
                   output ready);
endinterface

FILE: hw/rtl/zbem_lane.sv
// ----------------------------------------------------------------------------
// zbem_lane
// Zero test of one byte lane, gated by the valid byte count.
// ----------------------------------------------------------------------------
module zbem_lane #(
   parameter int unsigned LANE_INDEX = 0
) (
   input  logic [7:0]                     lane_byte,
   input  logic [zbem_pkg::VB_BITS-1:0]   vb,
   output logic                           nonzero
);

   logic in_range;

   assign in_range = vb > zbem_pkg::VB_BITS'(LANE_INDEX);
   assign nonzero  = in_range && (lane_byte != 8'd0);

endmodule

FILE: hw/rtl/zbem_scan.sv
// ----------------------------------------------------------------------------
// zbem_scan
// Byte lanes side by side, merged into one nonzero flag and registered.
// ----------------------------------------------------------------------------
module zbem_scan #(
   parameter int unsigned LANE_BYTES = zbem_pkg::DEF_LANE_BYTES
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           load,
   input  logic                           consume,
   input  logic                           mode,
   input  logic [zbem_pkg::DATA_BITS-1:0] data_word,
   input  logic [zbem_pkg::VB_BITS-1:0]   valid_bytes,
   input  logic                           block_last,
   output logic                           scan_valid,
   output zbem_pkg::scan_type             scan
);

   logic [zbem_pkg::VB_BITS-1:0] vb_clamp;
   logic [LANE_BYTES-1:0]        lane_nz;
   logic                         s1_valid_ff, s1_valid_in;
   zbem_pkg::scan_type           s1_ff, s1_in;

   assign vb_clamp = (valid_bytes > zbem_pkg::VB_BITS'(LANE_BYTES))
                   ? zbem_pkg::VB_BITS'(LANE_BYTES) : valid_bytes;

   for (genvar g = 0; g < LANE_BYTES; g++) begin : g_lane
      zbem_lane #(.LANE_INDEX(g)) u_lane (
         .lane_byte (data_word[8*g +: 8]),
         .vb        (vb_clamp),
         .nonzero   (lane_nz[g])
      );
   end

   // merge of the lanes
   always_comb begin
      s1_in.mode    = mode;
      s1_in.nonzero = |lane_nz;
      s1_in.vb      = vb_clamp;
      s1_in.last    = block_last;
   end

   assign s1_valid_in = load ? 1'b1 : (consume ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         s1_ff <= s1_in;
      end
   end

   assign scan_valid = s1_valid_ff;
   assign scan       = s1_ff;

   a_hold_until_consumed: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !consume |=> s1_valid_ff)
      else $error("scan stage dropped a transaction");

   a_no_consume_empty: assert property (@(posedge clock) disable iff (reset)
      consume |-> s1_valid_ff)
      else $error("scan stage consumed while empty");

endmodule

FILE: hw/rtl/zbem_tracker.sv
// ----------------------------------------------------------------------------
// zbem_tracker
// Block and extent state: closes blocks, grows and emits data extents.
// ----------------------------------------------------------------------------
module zbem_tracker #(
   parameter int unsigned OFFSET_BITS = zbem_pkg::DEF_OFFSET_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  zbem_pkg::scan_type     scan,
   output logic                   push,
   output logic [OFFSET_BITS-1:0] res_offset,
   output logic [OFFSET_BITS-1:0] res_length,
   output logic [OFFSET_BITS-1:0] res_total,
   output logic                   res_final
);

   localparam int unsigned CB = zbem_pkg::COUNT_BITS;

   function automatic logic [OFFSET_BITS-1:0] sat_add(
      input logic [OFFSET_BITS-1:0] a,
      input logic [OFFSET_BITS-1:0] b
   );
      logic [OFFSET_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[OFFSET_BITS] ? {OFFSET_BITS{1'b1}} : s[OFFSET_BITS-1:0];
   endfunction

   logic [OFFSET_BITS-1:0] fpos_ff, bpos_ff, ext_start_ff, ext_bytes_ff, total_ff;
   logic [CB-1:0]          bcount_ff;
   logic                   bnz_ff;

   logic                   data_step, eof_step;
   logic [CB:0]            cnt_sum;
   logic [CB-1:0]          cnt_acc, close_cnt;
   logic                   nz_acc, close_nz;
   logic [OFFSET_BITS-1:0] fpos_in, close_cntx, fpos_dec;
   logic                   has_cnt, ext_open, grow, closed;
   logic [OFFSET_BITS-1:0] ext_start_in, ext_bytes_in, total_in;

   assign data_step = step && (scan.mode == zbem_pkg::MODE_DATA);
   assign eof_step  = step && (scan.mode == zbem_pkg::MODE_EOF);

   assign cnt_sum = {1'b0, bcount_ff} + (CB+1)'(scan.vb);
   assign cnt_acc = cnt_sum[CB] ? {CB{1'b1}} : cnt_sum[CB-1:0];
   assign nz_acc  = bnz_ff | scan.nonzero;
   assign fpos_in = sat_add(fpos_ff, OFFSET_BITS'(scan.vb));

   // end of file closes the partial block without the current word
   assign close_cnt  = eof_step ? bcount_ff : cnt_acc;
   assign close_nz   = eof_step ? bnz_ff : nz_acc;
   assign close_cntx = OFFSET_BITS'(close_cnt);

   assign has_cnt  = close_cnt != '0;
   assign ext_open = ext_bytes_ff != '0;
   assign grow     = has_cnt && close_nz;
   assign closed   = has_cnt && !close_nz && ext_open;

   assign ext_start_in = (grow && !ext_open) ? bpos_ff : ext_start_ff;
   assign ext_bytes_in = grow ? sat_add(ext_bytes_ff, close_cntx)
                       : (closed ? '0 : ext_bytes_ff);
   assign total_in     = grow ? sat_add(total_ff, close_cntx) : total_ff;

   assign fpos_dec = (fpos_ff == '0) ? '0 : fpos_ff - OFFSET_BITS'(1);

   always_ff @(posedge clock) begin
      if (reset || eof_step) begin
         fpos_ff      <= '0;
         bpos_ff      <= '0;
         bnz_ff       <= 1'b0;
         bcount_ff    <= '0;
         ext_start_ff <= '0;
         ext_bytes_ff <= '0;
         total_ff     <= '0;
      end else if (data_step) begin
         fpos_ff <= fpos_in;
         if (scan.last) begin
            bpos_ff      <= fpos_in;
            bnz_ff       <= 1'b0;
            bcount_ff    <= '0;
            ext_start_ff <= ext_start_in;
            ext_bytes_ff <= ext_bytes_in;
            total_ff     <= total_in;
         end else begin
            bnz_ff    <= nz_acc;
            bcount_ff <= cnt_acc;
         end
      end
   end

   assign push       = (data_step && scan.last && closed) || eof_step;
   assign res_offset = closed ? ext_start_ff
                     : ((ext_bytes_in != '0) ? ext_start_in : fpos_dec);
   assign res_length = closed ? ext_bytes_ff
                     : ((ext_bytes_in != '0) ? ext_bytes_in : OFFSET_BITS'(1));
   assign res_total  = total_in;
   assign res_final  = eof_step;

   a_eof_emits: assert property (@(posedge clock) disable iff (reset)
      eof_step |-> push && res_final)
      else $error("end of file without an extent");

   a_nonempty_extent: assert property (@(posedge clock) disable iff (reset)
      push |-> res_length != '0)
      else $error("empty extent emitted");

   a_eof_clears: assert property (@(posedge clock) disable iff (reset)
      eof_step |=> fpos_ff == '0 && ext_bytes_ff == '0 && total_ff == '0)
      else $error("state not cleared after end of file");

endmodule

FILE: hw/rtl/zero_block_extent_mapper_core.sv
// ----------------------------------------------------------------------------
// zero_block_extent_mapper_core
// Scans file words for all-zero blocks and emits the data extents between them.
// ----------------------------------------------------------------------------
// flow: the byte lanes register an accepted transaction; the block/extent
//   update consumes it; a two-entry result buffer on rsp absorbs stalls
// throughput: one transaction per cycle while the result buffer is not full
// reset: synchronous; clears all file, block and extent state and empties
//   the pipeline and the result buffer
module zero_block_extent_mapper_core #(
   parameter int unsigned OFFSET_BITS = zbem_pkg::DEF_OFFSET_BITS,
   parameter int unsigned LANE_BYTES  = zbem_pkg::DEF_LANE_BYTES
) (
   input  logic        clock,
   input  logic        reset,
   zbem_req_if.sink    req,
   zbem_rsp_if.source  rsp
);

   localparam int unsigned RW = 3*OFFSET_BITS + 1;

   logic               load, consume, scan_valid, push, pop, full;
   zbem_pkg::scan_type scan;

   logic [OFFSET_BITS-1:0] res_offset, res_length, res_total;
   logic                   res_final;

   logic [RW-1:0] buf_ff [2];
   logic [RW-1:0] head;
   logic          wr_ptr_ff, rd_ptr_ff;
   logic [1:0]    count_ff, count_in;

   assign full     = count_ff == 2'd2;
   assign consume  = scan_valid && !full;
   assign req.ready = !scan_valid || !full;
   assign load     = req.valid && req.ready;

   zbem_scan #(.LANE_BYTES(LANE_BYTES)) u_scan (
      .clock       (clock),
      .reset       (reset),
      .load        (load),
      .consume     (consume),
      .mode        (req.mode),
      .data_word   (req.data_word),
      .valid_bytes (req.valid_bytes),
      .block_last  (req.block_last),
      .scan_valid  (scan_valid),
      .scan        (scan)
   );

   zbem_tracker #(.OFFSET_BITS(OFFSET_BITS)) u_tracker (
      .clock      (clock),
      .reset      (reset),
      .step       (consume),
      .scan       (scan),
      .push       (push),
      .res_offset (res_offset),
      .res_length (res_length),
      .res_total  (res_total),
      .res_final  (res_final)
   );

   // two-entry result buffer
   assign pop      = rsp.valid && rsp.ready;
   assign count_in = count_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         buf_ff[wr_ptr_ff] <= {res_offset, res_length, res_total, res_final};
      end
   end

   assign head              = buf_ff[rd_ptr_ff];
   assign rsp.valid         = count_ff != 2'd0;
   assign rsp.extent_offset = head[RW-1 -: OFFSET_BITS];
   assign rsp.extent_length = head[2*OFFSET_BITS -: OFFSET_BITS];
   assign rsp.data_total    = head[OFFSET_BITS -: OFFSET_BITS];
   assign rsp.final_res     = head[0];

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("result buffer overflow");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("result buffer count out of range");

   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0 || count_ff == 2'd2) |-> wr_ptr_ff == rd_ptr_ff)
      else $error("result buffer pointers out of step");

endmodule
